@@ hw/rtl/ifpre_pkg.sv @@
package ifpre_pkg;

  localparam logic [7:0] HDR_BYTE = 8'hAA;
  localparam int unsigned PAYLOAD_LEN = 17;
  localparam int unsigned FIELD_CNT = 6;
  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic signed [16:0] WRAP_LIMIT = 17'sd18000;
  localparam logic signed [16:0] WRAP_SPAN = 17'sd36000;

  localparam logic [1:0] PH_HUNT1 = 2'd0;
  localparam logic [1:0] PH_HUNT2 = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  // Last payload byte position: count runs 0..PAYLOAD_LEN-1.
  localparam logic [4:0] LAST_POS = 5'(PAYLOAD_LEN - 1);
  localparam logic [4:0] FIELD_FIRST_POS = 5'd1;
  localparam logic [4:0] FIELD_LAST_POS = 5'd12;

  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } frame_t;

  typedef struct packed {
    logic   push;
    frame_t frame;
  } frame_push_t;

endpackage

@@ hw/rtl/ifpre_deframer.sv @@
module ifpre_deframer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic [7:0]           in_rx_byte,
  input  logic                 fifo_full,
  output logic                 in_full,
  output ifpre_pkg::frame_push_t fpush
);

  logic [1:0]  sync_phase_r, sync_phase_nxt;
  logic [4:0]  payload_count_r, payload_count_nxt;
  logic [7:0]  low_byte_hold_r;
  logic [15:0] field_regs_r [ifpre_pkg::FIELD_CNT];
  logic        accept;
  logic        in_body;
  logic        field_pos;
  logic [2:0]  field_idx;
  logic        frame_done;

  assign in_full = fifo_full;
  assign accept = in_push & ~fifo_full;
  assign in_body = (sync_phase_r == ifpre_pkg::PH_BODY);
  assign field_pos = (payload_count_r >= ifpre_pkg::FIELD_FIRST_POS) &&
                     (payload_count_r <= ifpre_pkg::FIELD_LAST_POS);
  // Even positions 2..12 close fields 0..5.
  assign field_idx = 3'(payload_count_r[4:1] - 4'd1);
  assign frame_done = accept & in_body & (payload_count_r == ifpre_pkg::LAST_POS);

  always_comb begin
    sync_phase_nxt = sync_phase_r;
    payload_count_nxt = payload_count_r;
    if (accept) begin
      case (sync_phase_r)
        ifpre_pkg::PH_HUNT2: begin
          sync_phase_nxt = (in_rx_byte == ifpre_pkg::HDR_BYTE) ?
                           ifpre_pkg::PH_BODY : ifpre_pkg::PH_HUNT1;
          payload_count_nxt = '0;
        end
        ifpre_pkg::PH_BODY: begin
          if (payload_count_r == ifpre_pkg::LAST_POS) begin
            sync_phase_nxt = ifpre_pkg::PH_HUNT1;
            payload_count_nxt = '0;
          end else begin
            payload_count_nxt = payload_count_r + 5'd1;
          end
        end
        default: begin
          sync_phase_nxt = (in_rx_byte == ifpre_pkg::HDR_BYTE) ?
                           ifpre_pkg::PH_HUNT2 : ifpre_pkg::PH_HUNT1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_phase_r <= ifpre_pkg::PH_HUNT1;
      payload_count_r <= '0;
    end else begin
      sync_phase_r <= sync_phase_nxt;
      payload_count_r <= payload_count_nxt;
    end
  end

  // Capture little-endian halves; payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept && in_body && field_pos) begin
      if (payload_count_r[0]) begin
        low_byte_hold_r <= in_rx_byte;
      end else begin
        field_regs_r[field_idx] <= {in_rx_byte, low_byte_hold_r};
      end
    end
  end

  assign fpush.push = frame_done;
  assign fpush.frame.yaw = field_regs_r[0];
  assign fpush.frame.pitch = field_regs_r[1];
  assign fpush.frame.roll = field_regs_r[2];
  assign fpush.frame.accel_x = field_regs_r[3];
  assign fpush.frame.accel_y = field_regs_r[4];
  assign fpush.frame.accel_z = field_regs_r[5];

  a_count_only_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    (payload_count_r != 5'd0) |-> in_body)
    else $error("payload count running outside frame body");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    payload_count_r <= ifpre_pkg::LAST_POS)
    else $error("payload count past last position");

endmodule

@@ hw/rtl/ifpre_frame_fifo.sv @@
module ifpre_frame_fifo #(
  parameter int unsigned DEPTH = ifpre_pkg::FIFO_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ifpre_pkg::frame_push_t fpush,
  output logic                   full,
  output logic                   empty,
  input  logic                   pop,
  output ifpre_pkg::frame_t      head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  ifpre_pkg::frame_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full = (count_r == CNT_FULL);
  assign empty = (count_r == '0);
  assign do_push = fpush.push & ~full;
  assign do_pop = pop & ~empty;
  assign head = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= fpush.frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("frame queue count overflow");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("frame queue lost a push");

endmodule

@@ hw/rtl/ifpre_rate_calc.sv @@
module ifpre_rate_calc (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     fifo_empty,
  input  ifpre_pkg::frame_t        head,
  output logic                     fifo_pop,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic signed [15:0]       out_roll_cdeg,
  output logic signed [15:0]       out_pitch_cdeg,
  output logic signed [15:0]       out_yaw_cdeg,
  output logic signed [15:0]       out_accel_x_raw,
  output logic signed [15:0]       out_accel_y_raw,
  output logic signed [15:0]       out_accel_z_raw,
  output logic signed [16:0]       out_roll_rate_dps,
  output logic signed [16:0]       out_pitch_rate_dps,
  output logic signed [16:0]       out_yaw_rate_dps,
  output logic                     out_rates_valid
);

  logic               out_valid_r;
  logic               seen_frame_r;
  logic signed [15:0] prev_roll_r, prev_pitch_r, prev_yaw_r;
  logic               take;
  logic signed [16:0] dr, dp, dy_raw, dy;

  assign out_empty = ~out_valid_r;
  assign take = ~fifo_empty & (~out_valid_r | out_pop);
  assign fifo_pop = take;

  always_comb begin
    dr = 17'(head.roll) - 17'(prev_roll_r);
    dp = 17'(head.pitch) - 17'(prev_pitch_r);
    dy_raw = 17'(head.yaw) - 17'(prev_yaw_r);
    dy = dy_raw;
    if (dy_raw > ifpre_pkg::WRAP_LIMIT) begin
      dy = dy_raw - ifpre_pkg::WRAP_SPAN;
    end else if (dy_raw < -ifpre_pkg::WRAP_LIMIT) begin
      dy = dy_raw + ifpre_pkg::WRAP_SPAN;
    end
    if (!seen_frame_r) begin
      dr = '0;
      dp = '0;
      dy = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      seen_frame_r <= 1'b0;
      prev_roll_r <= '0;
      prev_pitch_r <= '0;
      prev_yaw_r <= '0;
    end else begin
      if (take) begin
        out_valid_r <= 1'b1;
        seen_frame_r <= 1'b1;
        prev_roll_r <= head.roll;
        prev_pitch_r <= head.pitch;
        prev_yaw_r <= head.yaw;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register; payload needs no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      out_roll_cdeg <= head.roll;
      out_pitch_cdeg <= head.pitch;
      out_yaw_cdeg <= head.yaw;
      out_accel_x_raw <= head.accel_x;
      out_accel_y_raw <= head.accel_y;
      out_accel_z_raw <= head.accel_z;
      out_roll_rate_dps <= dr;
      out_pitch_rate_dps <= dp;
      out_yaw_rate_dps <= dy;
      out_rates_valid <= seen_frame_r;
    end
  end

  a_first_rates_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rates_valid) |->
      (out_roll_rate_dps == '0 && out_pitch_rate_dps == '0 && out_yaw_rate_dps == '0))
    else $error("first frame carries nonzero rates");

  a_yaw_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_yaw_rate_dps <= ifpre_pkg::WRAP_LIMIT + ifpre_pkg::WRAP_LIMIT &&
                     out_yaw_rate_dps >= -(ifpre_pkg::WRAP_LIMIT + ifpre_pkg::WRAP_LIMIT)))
    else $error("yaw rate outside wrapped range");

endmodule

@@ hw/rtl/imu_frame_parser_rate_estimator.sv @@
// A frame goes through the frame queue, then the output register, to the out_ ports.
// One byte word per cycle unless in_full; one result per cycle while out_pop holds.
// in_full rises only when the frame queue is full, i.e. the result side stalls long enough.
// Reset (rst_n low, synchronous): hunt for the first header byte, queues empty,
// previous angles zero and no frame seen, so the next frame reports rates_valid = 0.
module imu_frame_parser_rate_estimator #(
  parameter int unsigned FIFO_DEPTH = ifpre_pkg::FIFO_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_rx_byte,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [15:0] out_roll_cdeg,
  output logic signed [15:0] out_pitch_cdeg,
  output logic signed [15:0] out_yaw_cdeg,
  output logic signed [15:0] out_accel_x_raw,
  output logic signed [15:0] out_accel_y_raw,
  output logic signed [15:0] out_accel_z_raw,
  output logic signed [16:0] out_roll_rate_dps,
  output logic signed [16:0] out_pitch_rate_dps,
  output logic signed [16:0] out_yaw_rate_dps,
  output logic               out_rates_valid
);

  ifpre_pkg::frame_push_t fpush;
  ifpre_pkg::frame_t      head;
  logic                   fifo_full;
  logic                   fifo_empty;
  logic                   fifo_pop;

  // Front end: hunt for the header pair, count payload bytes, assemble the
  // six little-endian fields and push a complete frame on its last byte.
  ifpre_deframer u_deframer (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_rx_byte(in_rx_byte),
    .fifo_full (fifo_full),
    .in_full   (in_full),
    .fpush     (fpush)
  );

  // Short frame queue: decouple byte intake from result draining.
  ifpre_frame_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_frame_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .fpush(fpush),
    .full (fifo_full),
    .empty(fifo_empty),
    .pop  (fifo_pop),
    .head (head)
  );

  // Back end: difference the angles against the previous frame, wrap yaw
  // once by a full turn, and hold the result in the output register.
  ifpre_rate_calc u_rate_calc (
    .clk               (clk),
    .rst_n             (rst_n),
    .fifo_empty        (fifo_empty),
    .head              (head),
    .fifo_pop          (fifo_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_roll_cdeg     (out_roll_cdeg),
    .out_pitch_cdeg    (out_pitch_cdeg),
    .out_yaw_cdeg      (out_yaw_cdeg),
    .out_accel_x_raw   (out_accel_x_raw),
    .out_accel_y_raw   (out_accel_y_raw),
    .out_accel_z_raw   (out_accel_z_raw),
    .out_roll_rate_dps (out_roll_rate_dps),
    .out_pitch_rate_dps(out_pitch_rate_dps),
    .out_yaw_rate_dps  (out_yaw_rate_dps),
    .out_rates_valid   (out_rates_valid)
  );

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  // One frame result as it should leave the block.
  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [16:0] roll_rate;
    logic signed [16:0] pitch_rate;
    logic signed [16:0] yaw_rate;
    logic               rates_valid;
  } imu_sample_t;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic [7:0]         in_rx_byte;
  logic               out_empty;
  logic               out_pop;
  logic signed [15:0] out_roll_cdeg;
  logic signed [15:0] out_pitch_cdeg;
  logic signed [15:0] out_yaw_cdeg;
  logic signed [15:0] out_accel_x_raw;
  logic signed [15:0] out_accel_y_raw;
  logic signed [15:0] out_accel_z_raw;
  logic signed [16:0] out_roll_rate_dps;
  logic signed [16:0] out_pitch_rate_dps;
  logic signed [16:0] out_yaw_rate_dps;
  logic               out_rates_valid;

  imu_frame_parser_rate_estimator uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_rx_byte        (in_rx_byte),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_roll_cdeg     (out_roll_cdeg),
    .out_pitch_cdeg    (out_pitch_cdeg),
    .out_yaw_cdeg      (out_yaw_cdeg),
    .out_accel_x_raw   (out_accel_x_raw),
    .out_accel_y_raw   (out_accel_y_raw),
    .out_accel_z_raw   (out_accel_z_raw),
    .out_roll_rate_dps (out_roll_rate_dps),
    .out_pitch_rate_dps(out_pitch_rate_dps),
    .out_yaw_rate_dps  (out_yaw_rate_dps),
    .out_rates_valid   (out_rates_valid)
  );

  // Frame results still owed by the block, oldest first.
  imu_sample_t pending_samples[$];

  // Deframer mirror: sync phase, payload position, split-word holding
  // register, collected fields and the angles of the last frame.
  logic [1:0]         sync_ph;
  logic [4:0]         body_pos;
  logic [7:0]         low_hold;
  logic [15:0]        field_words[ifpre_pkg::FIELD_CNT];
  logic signed [15:0] last_angles[3];  // roll, pitch, yaw
  bit                 frame_seen;

  int  words_sent;
  int  frames_checked;
  int  yaw_wraps;
  int  fail_count;
  bit  tx_gaps_on;
  bit  rx_stalls_on;

  // Free-running clock, 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Bail out if the run hangs; sized well past the slowest legal run.
  initial begin
    #2_000_000;
    $display("imu_frame_parser_rate_estimator verification failed");
    $finish;
  end

  // Idle length: mostly none, often short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advance the deframer mirror by one accepted byte word; queue the frame
  // result when the word closes a frame.
  function automatic void track_byte(logic [7:0] b);
    imu_sample_t s;
    int          dr, dp, dy;
    logic [4:0]  k;
    // Second header byte: a miss drops straight back to hunting.
    if (sync_ph == ifpre_pkg::PH_HUNT2) begin
      sync_ph  = (b == ifpre_pkg::HDR_BYTE) ? ifpre_pkg::PH_BODY : ifpre_pkg::PH_HUNT1;
      body_pos = '0;
      return;
    end
    // Any phase other than the body hunts for the first header byte.
    if (sync_ph != ifpre_pkg::PH_BODY) begin
      sync_ph = (b == ifpre_pkg::HDR_BYTE) ? ifpre_pkg::PH_HUNT2 : ifpre_pkg::PH_HUNT1;
      return;
    end
    // Payload bytes are never tested for the header value.
    k = body_pos;
    if (k >= ifpre_pkg::FIELD_FIRST_POS && k <= ifpre_pkg::FIELD_LAST_POS) begin
      if (k[0]) begin
        low_hold = b;
      end else begin
        field_words[3'((k - 5'd2) >> 1)] = {b, low_hold};
      end
    end
    if (k != ifpre_pkg::LAST_POS) begin
      body_pos = k + 5'd1;
      return;
    end
    sync_ph  = ifpre_pkg::PH_HUNT1;
    body_pos = '0;
    s.yaw     = field_words[0];
    s.pitch   = field_words[1];
    s.roll    = field_words[2];
    s.accel_x = field_words[3];
    s.accel_y = field_words[4];
    s.accel_z = field_words[5];
    dr = 0;
    dp = 0;
    dy = 0;
    // First frame after reset reports zero rates, flagged invalid.
    if (frame_seen) begin
      dr = int'(s.roll) - int'(last_angles[0]);
      dp = int'(s.pitch) - int'(last_angles[1]);
      dy = int'(s.yaw) - int'(last_angles[2]);
      // Wrap yaw once; exactly half a turn stays as it is.
      if (dy > ifpre_pkg::WRAP_LIMIT) begin
        dy = dy - ifpre_pkg::WRAP_SPAN;
        yaw_wraps++;
      end
      if (dy < -ifpre_pkg::WRAP_LIMIT) begin
        dy = dy + ifpre_pkg::WRAP_SPAN;
        yaw_wraps++;
      end
    end
    s.roll_rate   = 17'(dr);
    s.pitch_rate  = 17'(dp);
    s.yaw_rate    = 17'(dy);
    s.rates_valid = frame_seen;
    pending_samples.push_back(s);
    frame_seen     = 1'b1;
    last_angles[0] = s.roll;
    last_angles[1] = s.pitch;
    last_angles[2] = s.yaw;
  endfunction

  // Push one byte word, with an optional idle gap ahead of it. The valid
  // stays high between back-to-back words.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_gaps_on ? idle_len() : 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push    <= 1'b1;
    in_rx_byte <= b;
    // Hold until an edge sees the queue with room.
    do @(posedge clk); while (in_full);
    track_byte(b);
    words_sent++;
  endtask

  // Send header plus a 17-byte payload. fill < 0 gives random index and
  // reserved bytes, otherwise that value for all of them.
  task automatic send_frame(input logic [15:0] yaw, input logic [15:0] pitch,
                            input logic [15:0] roll, input logic [15:0] ax,
                            input logic [15:0] ay, input logic [15:0] az,
                            input int fill);
    logic [15:0] vals[ifpre_pkg::FIELD_CNT];
    int          i;
    vals[0] = yaw;
    vals[1] = pitch;
    vals[2] = roll;
    vals[3] = ax;
    vals[4] = ay;
    vals[5] = az;
    send_byte(ifpre_pkg::HDR_BYTE);
    send_byte(ifpre_pkg::HDR_BYTE);
    send_byte((fill < 0) ? 8'($urandom) : 8'(fill));
    for (i = 0; i < ifpre_pkg::FIELD_CNT; i++) begin
      send_byte(vals[i][7:0]);
      send_byte(vals[i][15:8]);
    end
    for (i = 0; i < 4; i++) begin
      send_byte((fill < 0) ? 8'($urandom) : 8'(fill));
    end
  endtask

  // Compare the result word at the output against the oldest expectation.
  task automatic check_result();
    imu_sample_t want;
    bit          bad;
    if (pending_samples.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("unexpected frame result: roll %0d pitch %0d yaw %0d", out_roll_cdeg,
                 out_pitch_cdeg, out_yaw_cdeg);
      end
      return;
    end
    want = pending_samples.pop_front();
    frames_checked++;
    bad = (out_roll_cdeg !== want.roll) || (out_pitch_cdeg !== want.pitch) ||
          (out_yaw_cdeg !== want.yaw) || (out_accel_x_raw !== want.accel_x) ||
          (out_accel_y_raw !== want.accel_y) || (out_accel_z_raw !== want.accel_z) ||
          (out_roll_rate_dps !== want.roll_rate) ||
          (out_pitch_rate_dps !== want.pitch_rate) ||
          (out_yaw_rate_dps !== want.yaw_rate) || (out_rates_valid !== want.rates_valid);
    if (bad) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("frame %0d expected: ang %0d %0d %0d acc %0d %0d %0d rate %0d %0d %0d v%0b",
                 frames_checked, want.roll, want.pitch, want.yaw, want.accel_x,
                 want.accel_y, want.accel_z, want.roll_rate, want.pitch_rate,
                 want.yaw_rate, want.rates_valid);
        $display("frame %0d actual:   ang %0d %0d %0d acc %0d %0d %0d rate %0d %0d %0d v%0b",
                 frames_checked, out_roll_cdeg, out_pitch_cdeg, out_yaw_cdeg,
                 out_accel_x_raw, out_accel_y_raw, out_accel_z_raw, out_roll_rate_dps,
                 out_pitch_rate_dps, out_yaw_rate_dps, out_rates_valid);
      end
    end
  endtask

  // Result side: take a word on each edge that sees pop with a result
  // waiting, then pick the pop level for the next cycle.
  initial begin : result_side
    int stall;
    stall = 0;
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) check_result();
      if (stall > 0) begin
        stall--;
        out_pop <= 1'b0;
      end else if (rx_stalls_on && $urandom_range(0, 99) < 20) begin
        stall = idle_len();
        out_pop <= (stall == 0);
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // First frame after reset, then extreme angle steps on roll and pitch,
  // and yaw steps on both sides of the wrap threshold.
  task automatic test_extremes();
    // First frame: rates zero and invalid; fields at their extremes.
    send_frame(16'h0000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 8'hFF);
    // Largest swings: roll +65535, pitch -65535.
    send_frame(16'd18000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 16'h8000, 8'h00);
    // Yaw back by exactly half a turn: not wrapped.
    send_frame(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, -1);
    // Just past half a turn, both directions: wrapped.
    send_frame(16'd18001, 16'h1234, 16'hEDCB, 16'h5555, 16'hAAAA, 16'h0F0F, -1);
    send_frame(16'h0000, 16'hFFFF, 16'h0001, 16'hF0F0, 16'h3333, 16'hCCCC, -1);
    send_frame(-16'sd18001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, -1);
    // Yaw from top to bottom of the range: wrapped once only.
    send_frame(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, -1);
    send_frame(16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, -1);
  endtask

  // Header misses, header bytes inside the payload, and a triple header.
  task automatic test_header_cases();
    // Bad second header byte, then a noise byte, then a clean frame.
    send_byte(ifpre_pkg::HDR_BYTE);
    send_byte(8'h55);
    send_byte(8'h00);
    // Payload made of header bytes only: the count alone ends the frame.
    send_frame(16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA,
               ifpre_pkg::HDR_BYTE);
    // Three header bytes: the third is taken as the index byte.
    send_byte(ifpre_pkg::HDR_BYTE);
    send_frame(16'h4321, 16'h00AA, 16'hAA00, 16'h0102, 16'h0304, 16'h0506, -1);
  endtask

  // Pick a field word: extremes now and then, else random.
  function automatic logic [15:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 16'h8000;
    if (r < 8) return 16'h7FFF;
    if (r < 11) return 16'h0000;
    if (r < 14) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // Pick a yaw word; often a step near the wrap threshold from the last yaw.
  function automatic logic [15:0] pick_yaw();
    int step;
    case ($urandom_range(0, 9))
      0: step = ifpre_pkg::WRAP_LIMIT;
      1: step = -ifpre_pkg::WRAP_LIMIT;
      2: step = ifpre_pkg::WRAP_LIMIT + 1;
      3: step = -ifpre_pkg::WRAP_LIMIT - 1;
      4, 5: step = $urandom_range(0, 40000) - 20000;
      default: return pick_word();
    endcase
    return 16'(int'(last_angles[2]) + step);
  endfunction

  // Mostly well-formed frames with random content; the rest broken
  // headers and loose noise. Gap and stall modes change every few rounds.
  task automatic test_random_stream(input int word_budget);
    int          stop_at;
    int          rounds;
    int          r;
    int          n;
    logic [7:0]  b;
    stop_at = words_sent + word_budget;
    rounds  = 0;
    while (words_sent < stop_at) begin
      if (rounds % 6 == 0) begin
        tx_gaps_on   = ($urandom_range(0, 3) != 0);
        rx_stalls_on = ($urandom_range(0, 3) != 0);
      end
      rounds++;
      r = $urandom_range(0, 99);
      if (r < 75) begin
        send_frame(pick_yaw(), pick_word(), pick_word(), pick_word(), pick_word(),
                   pick_word(), -1);
      end else if (r < 87) begin
        b = 8'($urandom);
        if (b == ifpre_pkg::HDR_BYTE) b = 8'h55;
        send_byte(ifpre_pkg::HDR_BYTE);
        send_byte(b);
      end else begin
        n = $urandom_range(1, 5);
        repeat (n) send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    int i;
    rst_n      <= 1'b0;
    in_push    <= 1'b0;
    in_rx_byte <= '0;
    sync_ph    = ifpre_pkg::PH_HUNT1;
    body_pos   = '0;
    low_hold   = '0;
    for (i = 0; i < ifpre_pkg::FIELD_CNT; i++) field_words[i] = '0;
    for (i = 0; i < 3; i++) last_angles[i] = '0;
    frame_seen     = 1'b0;
    words_sent     = 0;
    frames_checked = 0;
    yaw_wraps      = 0;
    fail_count     = 0;
    tx_gaps_on     = 1'b1;
    rx_stalls_on   = 1'b1;

    // Hold reset, then release it once for the whole run.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_header_cases();
    test_random_stream(760);

    // Drop the valid, drain the owed results, then let the pipe settle.
    in_push <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d byte words; %0d frame results checked, %0d with wrapped yaw",
             words_sent, frames_checked, yaw_wraps);
    $display("random gaps and stalls on both sides, header misses and noise mixed in");
    if (fail_count == 0) begin
      $display("imu_frame_parser_rate_estimator verification clean");
    end else begin
      $display("imu_frame_parser_rate_estimator verification failed");
    end
    $finish;
  end

endmodule
